>>> rtl/box_mesh_vertex_generator_assert.svh
// Assertion macros of the box mesh generator RTL.
`ifndef BOX_MESH_VERTEX_GENERATOR_ASSERT_SVH
`define BOX_MESH_VERTEX_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define BMVG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box mesh generator check failed");

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define BMVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box mesh generator check failed");

`endif

>>> rtl/bmvg_pkg.sv
// Types and constants of the box mesh vertex generator.
package bmvg_pkg;

  localparam int MaxSegments = 255;

  localparam int DivNumW  = 24;
  localparam int DivDenW  = 9;
  localparam int DivLanes = 4;

  typedef enum logic [2:0] {
    RegBoxWidth  = 3'd0,
    RegBoxHeight = 3'd1,
    RegBoxDepth  = 3'd2,
    RegSegsX     = 3'd3,
    RegSegsY     = 3'd4,
    RegSegsZ     = 3'd5
  } cfg_reg_t;

  localparam logic [2:0] FacePosX = 3'd0;
  localparam logic [2:0] FaceNegX = 3'd1;
  localparam logic [2:0] FacePosY = 3'd2;
  localparam logic [2:0] FaceNegY = 3'd3;
  localparam logic [2:0] FacePosZ = 3'd4;
  localparam logic [2:0] FaceNegZ = 3'd5;

  // Side information that travels with an item through the divider.
  typedef struct packed {
    logic [2:0]  face;
    logic        neg_u;
    logic        neg_v;
    logic [14:0] half_w;
    logic        quad_valid;
    logic [18:0] corner_a;
    logic [8:0]  stride;
  } side_t;

  function automatic logic [7:0] clamp_segs(logic [7:0] s);
    logic [7:0] r;
    r = s;
    if (s == 8'd0) r = 8'd1;
    else if (int'(s) > MaxSegments) r = 8'(MaxSegments);
    return r;
  endfunction

endpackage

>>> rtl/bmvg_ifs.sv
// Channel interfaces of the box mesh vertex generator.
interface bmvg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface bmvg_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] face;
  logic [7:0] grid_col;
  logic [7:0] grid_row;
  modport source (output valid, face, grid_col, grid_row, input ready);
  modport sink (input valid, face, grid_col, grid_row, output ready);
endinterface

interface bmvg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [2:0]         normal_code;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [18:0]        corner_a;
  logic [18:0]        corner_b;
  logic [18:0]        corner_c;
  logic [18:0]        corner_d;
  logic               quad_valid;
  modport source (output valid, pos_x, pos_y, pos_z, normal_code, tex_u, tex_v,
                  corner_a, corner_b, corner_c, corner_d, quad_valid, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, normal_code, tex_u, tex_v,
                corner_a, corner_b, corner_c, corner_d, quad_valid, output ready);
endinterface

>>> rtl/bmvg_div.sv
// Pipelined multi-lane restoring divider, one quotient bit per stage.
module bmvg_div #(
  parameter int NW    = 24,
  parameter int DW    = 9,
  parameter int LANES = 4,
  parameter int SW    = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [LANES-1:0][NW-1:0]       num,
  input  logic [LANES-1:0][DW-1:0]       den,
  input  logic [SW-1:0]                  side_in,
  output logic                           out_vld,
  output logic [LANES-1:0][NW-1:0]       quo,
  output logic [SW-1:0]                  side_out
);

  logic [NW-1:0]                         vld;
  logic [NW-1:0][LANES-1:0][DW-1:0]      rem;
  logic [NW-1:0][LANES-1:0][NW-1:0]      nq;
  logic [NW-1:0][LANES-1:0][DW-1:0]      dv;
  logic [NW-1:0][SW-1:0]                 side;
  logic [NW-1:0][LANES-1:0][DW-1:0]      rem_next;
  logic [NW-1:0][LANES-1:0][NW-1:0]      nq_next;
  logic [NW-1:0][LANES-1:0][DW-1:0]      dv_next;

  always_comb begin
    logic [DW-1:0] r_src;
    logic [NW-1:0] q_src;
    logic [DW-1:0] d_src;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    for (int s = 0; s < NW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          r_src = '0;
          q_src = num[l];
          d_src = den[l];
        end else begin
          r_src = rem[s-1][l];
          q_src = nq[s-1][l];
          d_src = dv[s-1][l];
        end
        t    = {r_src, q_src[NW-1]};
        diff = t - {1'b0, d_src};
        ge   = t >= {1'b0, d_src};
        rem_next[s][l] = ge ? diff[DW-1:0] : t[DW-1:0];
        nq_next[s][l]  = {q_src[NW-2:0], ge};
        dv_next[s][l]  = d_src;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem     <= rem_next;
      nq      <= nq_next;
      dv      <= dv_next;
      side[0] <= side_in;
      for (int s = 1; s < NW; s++) begin
        side[s] <= side[s-1];
      end
    end
  end

  assign out_vld  = vld[NW-1];
  assign quo      = nq[NW-1];
  assign side_out = side[NW-1];

endmodule

>>> rtl/box_mesh_vertex_generator.sv
// Top level of the box mesh vertex generator.
//
// The cfg channel writes the box extents (index 0 to 2, unsigned Q8.8) and the
// segment counts per axis (index 3 to 5); it is always ready, and a write to
// an unused index is dropped. The user must change configuration only while
// no request is in flight; the block does not enforce it. Each transaction
// on the req channel names a face, a grid column and a grid row, and
// produces exactly one transaction on the rsp channel with the vertex
// position, normal code, texture coordinate and the four corner indices of
// the quad whose lower corner is that vertex. The pipeline takes one request
// per cycle while it is not stalled. A response passes through one input
// stage, one stage of multiplies and index arithmetic, 24 stages of the
// divider (one quotient bit per stage) and the output register.
// When the receiver holds rsp.ready low with a response waiting, the whole
// pipeline freezes and req.ready drops, so nothing is lost or repeated.
// A synchronous reset empties the pipeline and restores a 1.0 cube with one
// segment per axis.
module box_mesh_vertex_generator (
  input logic            clk,
  input logic            rst,
  bmvg_cfg_if.sink       cfg,
  bmvg_req_if.sink       req,
  bmvg_rsp_if.source     rsp
);

  localparam int NW = bmvg_pkg::DivNumW;
  localparam int DW = bmvg_pkg::DivDenW;
  localparam int LN = bmvg_pkg::DivLanes;
  localparam int SW = $bits(bmvg_pkg::side_t);

  // Configuration registers.
  logic [15:0] box_width, box_height, box_depth;
  logic [7:0]  segs_x, segs_y, segs_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_width  <= 16'd256;
      box_height <= 16'd256;
      box_depth  <= 16'd256;
      segs_x     <= 8'd1;
      segs_y     <= 8'd1;
      segs_z     <= 8'd1;
    end else if (cfg.valid) begin
      unique case (bmvg_pkg::cfg_reg_t'(cfg.index))
        bmvg_pkg::RegBoxWidth:  box_width  <= cfg.data;
        bmvg_pkg::RegBoxHeight: box_height <= cfg.data;
        bmvg_pkg::RegBoxDepth:  box_depth  <= cfg.data;
        bmvg_pkg::RegSegsX:     segs_x     <= cfg.data[7:0];
        bmvg_pkg::RegSegsY:     segs_y     <= cfg.data[7:0];
        bmvg_pkg::RegSegsZ:     segs_z     <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  logic [7:0] sx, sy, sz;
  assign sx = bmvg_pkg::clamp_segs(segs_x);
  assign sy = bmvg_pkg::clamp_segs(segs_y);
  assign sz = bmvg_pkg::clamp_segs(segs_z);

  // Vertex counts of the x, y and z face pairs. They are registered from the
  // configuration, in time for any request accepted after the last write.
  logic [16:0] cnt_x, cnt_y, cnt_z;
  logic [17:0] prod_x, prod_y, prod_z;
  assign prod_x = ({1'b0, sz} + 9'd1) * ({1'b0, sy} + 9'd1);
  assign prod_y = ({1'b0, sx} + 9'd1) * ({1'b0, sz} + 9'd1);
  assign prod_z = ({1'b0, sx} + 9'd1) * ({1'b0, sy} + 9'd1);

  always_ff @(posedge clk) begin
    cnt_x <= prod_x[16:0];
    cnt_y <= prod_y[16:0];
    cnt_z <= prod_z[16:0];
  end

  // The whole pipeline advances unless a response is waiting to be taken.
  logic rsp_vld;
  logic en;
  assign en        = !rsp_vld || rsp.ready;
  assign req.ready = en;

  // Stage 1: face decode and saturation of the column and row.
  logic [2:0]  face_c;
  logic [7:0]  cols, rows;
  logic [15:0] ext_u, ext_v, ext_w;
  logic        su_neg, sv_neg;

  always_comb begin
    face_c = (req.face > bmvg_pkg::FaceNegZ) ? bmvg_pkg::FaceNegZ : req.face;
    unique case (face_c)
      bmvg_pkg::FacePosX, bmvg_pkg::FaceNegX: begin
        cols   = sz;
        rows   = sy;
        ext_u  = box_depth;
        ext_v  = box_height;
        ext_w  = box_width;
        su_neg = (face_c == bmvg_pkg::FacePosX);
        sv_neg = 1'b1;
      end
      bmvg_pkg::FacePosY, bmvg_pkg::FaceNegY: begin
        cols   = sx;
        rows   = sz;
        ext_u  = box_width;
        ext_v  = box_depth;
        ext_w  = box_height;
        su_neg = 1'b0;
        sv_neg = (face_c == bmvg_pkg::FaceNegY);
      end
      default: begin
        cols   = sx;
        rows   = sy;
        ext_u  = box_width;
        ext_v  = box_height;
        ext_w  = box_depth;
        su_neg = (face_c == bmvg_pkg::FaceNegZ);
        sv_neg = 1'b1;
      end
    endcase
  end

  logic        s1_vld;
  logic [2:0]  s1_face;
  logic [7:0]  s1_c, s1_r, s1_cols, s1_rows;
  logic [15:0] s1_eu, s1_ev, s1_ew;
  logic        s1_su_neg, s1_sv_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_face   <= face_c;
      s1_c      <= (req.grid_col > cols) ? cols : req.grid_col;
      s1_r      <= (req.grid_row > rows) ? rows : req.grid_row;
      s1_cols   <= cols;
      s1_rows   <= rows;
      s1_eu     <= ext_u;
      s1_ev     <= ext_v;
      s1_ew     <= ext_w;
      s1_su_neg <= su_neg;
      s1_sv_neg <= sv_neg;
    end
  end

  // Stage 2: numerator magnitudes, divisors and the lower corner index.
  // The coordinate is (2c - n) * E / (2n); the divider works on magnitudes
  // and the sign is restored at the output.
  logic [8:0]  two_c, two_r, cu, cv, mag_u, mag_v, stride;
  logic        lt_u, lt_v, qv;
  logic [24:0] prod_u, prod_v;
  logic [16:0] sr;
  logic [19:0] base, corner_full;
  logic [LN-1:0][NW-1:0] num;
  logic [LN-1:0][DW-1:0] den;
  bmvg_pkg::side_t side;

  always_comb begin
    two_c  = {s1_c, 1'b0};
    two_r  = {s1_r, 1'b0};
    cu     = {1'b0, s1_cols};
    cv     = {1'b0, s1_rows};
    lt_u   = two_c < cu;
    lt_v   = two_r < cv;
    mag_u  = lt_u ? (cu - two_c) : (two_c - cu);
    mag_v  = lt_v ? (cv - two_r) : (two_r - cv);
    prod_u = mag_u * s1_eu;
    prod_v = mag_v * s1_ev;
    num[0] = prod_u[NW-1:0];
    num[1] = prod_v[NW-1:0];
    num[2] = {s1_c, 16'h0000};
    num[3] = {s1_rows - s1_r, 16'h0000};
    den[0] = {s1_cols, 1'b0};
    den[1] = {s1_rows, 1'b0};
    den[2] = cu;
    den[3] = cv;

    unique case (s1_face)
      bmvg_pkg::FacePosX: base = 20'd0;
      bmvg_pkg::FaceNegX: base = 20'(cnt_x);
      bmvg_pkg::FacePosY: base = 20'({cnt_x, 1'b0});
      bmvg_pkg::FaceNegY: base = 20'({cnt_x, 1'b0}) + 20'(cnt_y);
      bmvg_pkg::FacePosZ: base = 20'({cnt_x, 1'b0}) + 20'({cnt_y, 1'b0});
      default:            base = 20'({cnt_x, 1'b0}) + 20'({cnt_y, 1'b0}) + 20'(cnt_z);
    endcase
    stride      = cu + 9'd1;
    sr          = stride * s1_r;
    corner_full = base + 20'(s1_c) + 20'(sr);
    qv          = (s1_c < s1_cols) && (s1_r < s1_rows);

    side.face       = s1_face;
    side.neg_u      = lt_u ^ s1_su_neg;
    side.neg_v      = lt_v ^ s1_sv_neg;
    side.half_w     = s1_ew[15:1];
    side.quad_valid = qv;
    side.corner_a   = corner_full[18:0];
    side.stride     = stride;
  end

  logic                  s2_vld;
  logic [LN-1:0][NW-1:0] s2_num;
  logic [LN-1:0][DW-1:0] s2_den;
  bmvg_pkg::side_t       s2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_num  <= num;
      s2_den  <= den;
      s2_side <= side;
    end
  end

  // Divider: lane 0 and 1 give the in-plane coordinates, lane 2 and 3 the
  // texture coordinates.
  logic                  d_vld;
  logic [LN-1:0][NW-1:0] quo;
  logic [SW-1:0]         d_side_bits;
  bmvg_pkg::side_t       d_side;

  bmvg_div #(
    .NW    (NW),
    .DW    (DW),
    .LANES (LN),
    .SW    (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s2_vld),
    .num      (s2_num),
    .den      (s2_den),
    .side_in  (s2_side),
    .out_vld  (d_vld),
    .quo      (quo),
    .side_out (d_side_bits)
  );

  assign d_side = bmvg_pkg::side_t'(d_side_bits);

  // Output stage: restore signs, place the axes and finish the corners.
  logic [15:0] pu, pv, pw, px, py, pz;
  logic [18:0] ca, cb, cc, cd;

  always_comb begin
    pu = d_side.neg_u ? (16'd0 - quo[0][15:0]) : quo[0][15:0];
    pv = d_side.neg_v ? (16'd0 - quo[1][15:0]) : quo[1][15:0];
    pw = d_side.face[0] ? (16'd0 - {1'b0, d_side.half_w}) : {1'b0, d_side.half_w};
    unique case (d_side.face)
      bmvg_pkg::FacePosX, bmvg_pkg::FaceNegX: begin
        px = pw;
        py = pv;
        pz = pu;
      end
      bmvg_pkg::FacePosY, bmvg_pkg::FaceNegY: begin
        px = pu;
        py = pw;
        pz = pv;
      end
      default: begin
        px = pu;
        py = pv;
        pz = pw;
      end
    endcase
    ca = d_side.corner_a;
    cb = ca + 19'(d_side.stride);
    cc = cb + 19'd1;
    cd = ca + 19'd1;
    if (!d_side.quad_valid) begin
      ca = '0;
      cb = '0;
      cc = '0;
      cd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_vld <= 1'b0;
    end else if (en) begin
      rsp_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.pos_x       <= px;
      rsp.pos_y       <= py;
      rsp.pos_z       <= pz;
      rsp.normal_code <= d_side.face;
      rsp.tex_u       <= quo[2][16:0];
      rsp.tex_v       <= quo[3][16:0];
      rsp.corner_a    <= ca;
      rsp.corner_b    <= cb;
      rsp.corner_c    <= cc;
      rsp.corner_d    <= cd;
      rsp.quad_valid  <= d_side.quad_valid;
    end
  end

  assign rsp.valid = rsp_vld;

  `include "box_mesh_vertex_generator_assert.svh"

  // A missing quad reports all-zero corners; the check covers corner_a and corner_d.
  `BMVG_ASSERT_SAME(a_no_quad_zero, rsp_vld && !rsp.quad_valid,
    rsp.corner_a == 19'd0 && rsp.corner_d == 19'd0)
  // The fourth corner is always the right-hand neighbor of the first.
  `BMVG_ASSERT_SAME(a_corner_d_next, rsp_vld && rsp.quad_valid,
    rsp.corner_d == rsp.corner_a + 19'd1)
  // The texture coordinates never exceed one.
  `BMVG_ASSERT_SAME(a_tex_range, rsp_vld,
    rsp.tex_u <= 17'h10000 && rsp.tex_v <= 17'h10000)
  // A waiting response freezes the front of the pipeline.
  `BMVG_ASSERT_NEXT(a_stall_freeze, rsp_vld && !rsp.ready,
    $stable(s1_vld) && $stable(s2_vld))

endmodule

>>> verif/tb_box_mesh_vertex_generator.sv
// Self-checking testbench of the box mesh vertex generator.
module tb_box_mesh_vertex_generator;

  timeunit 1ns;
  timeprecision 1ps;

  // The settle time after the drain leaves a margin before the registers are
  // written.
  localparam int SettleCycles = 40;

  // One vertex record as the block reports it.
  typedef struct {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [2:0]         normal_code;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [18:0]        corner_a;
    logic [18:0]        corner_b;
    logic [18:0]        corner_c;
    logic [18:0]        corner_d;
    logic               quad_valid;
  } vertex_t;

  logic clk;
  logic rst;

  bmvg_cfg_if cfg_ch ();
  bmvg_req_if req_ch ();
  bmvg_rsp_if rsp_ch ();

  box_mesh_vertex_generator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Our own copy of the registers, updated whenever a write transaction
  // is accepted.
  logic [15:0] ext_x, ext_y, ext_z;
  logic [7:0]  seg_x, seg_y, seg_z;

  // Vertices still owed by the block, oldest first.
  vertex_t pending_vertices[$];
  int      error_count = 0;

  // While set, neither side idles, so the pipeline runs at full rate.
  bit      no_idle = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint seg_count(logic [7:0] s);
    longint v;
    v = s;
    if (v < 1) v = 1;
    if (v > bmvg_pkg::MaxSegments) v = bmvg_pkg::MaxSegments;
    return v;
  endfunction

  // Truncate toward zero of pos*ext/n - ext/2, done exactly in integers.
  function automatic longint plane_coord(longint pos, longint ext, longint n);
    return ((2 * pos - n) * ext) / (2 * n);
  endfunction

  // Computes the vertex record that a request should produce under the
  // current register values.
  function automatic vertex_t predict_vertex(logic [2:0] face_in, logic [7:0] col_in,
                                             logic [7:0] row_in);
    vertex_t v;
    longint sx, sy, sz, cnt_x, cnt_y, cols, rows, base, c, r, pu, pv, half, stride;
    longint ext[3];
    longint pos[3];
    int ua, va, wa;
    bit neg_u, neg_v;
    logic [2:0] face;
    sx = seg_count(seg_x);
    sy = seg_count(seg_y);
    sz = seg_count(seg_z);
    ext[0] = ext_x;
    ext[1] = ext_y;
    ext[2] = ext_z;
    cnt_x = (sz + 1) * (sy + 1);
    cnt_y = (sx + 1) * (sz + 1);
    // Face codes six and seven behave as the -z face.
    face = (face_in > bmvg_pkg::FaceNegZ) ? bmvg_pkg::FaceNegZ : face_in;
    case (face)
      bmvg_pkg::FacePosX: begin
        ua = 2; va = 1; wa = 0; neg_u = 1; neg_v = 1; cols = sz; rows = sy; base = 0;
      end
      bmvg_pkg::FaceNegX: begin
        ua = 2; va = 1; wa = 0; neg_u = 0; neg_v = 1; cols = sz; rows = sy; base = cnt_x;
      end
      bmvg_pkg::FacePosY: begin
        ua = 0; va = 2; wa = 1; neg_u = 0; neg_v = 0; cols = sx; rows = sz;
        base = 2 * cnt_x;
      end
      bmvg_pkg::FaceNegY: begin
        ua = 0; va = 2; wa = 1; neg_u = 0; neg_v = 1; cols = sx; rows = sz;
        base = 2 * cnt_x + cnt_y;
      end
      bmvg_pkg::FacePosZ: begin
        ua = 0; va = 1; wa = 2; neg_u = 0; neg_v = 1; cols = sx; rows = sy;
        base = 2 * cnt_x + 2 * cnt_y;
      end
      default: begin
        ua = 0; va = 1; wa = 2; neg_u = 1; neg_v = 1; cols = sx; rows = sy;
        base = 2 * cnt_x + 2 * cnt_y + (sx + 1) * (sy + 1);
      end
    endcase
    c = (col_in > cols) ? cols : col_in;
    r = (row_in > rows) ? rows : row_in;
    pu = plane_coord(c, ext[ua], cols);
    pv = plane_coord(r, ext[va], rows);
    half = ext[wa] / 2;
    pos[ua] = neg_u ? -pu : pu;
    pos[va] = neg_v ? -pv : pv;
    pos[wa] = face[0] ? -half : half;
    v.pos_x = 16'(pos[0]);
    v.pos_y = 16'(pos[1]);
    v.pos_z = 16'(pos[2]);
    v.normal_code = face;
    v.tex_u = 17'((c << 16) / cols);
    v.tex_v = 17'(((rows - r) << 16) / rows);
    v.quad_valid = (c < cols) && (r < rows);
    if (v.quad_valid) begin
      stride = cols + 1;
      v.corner_a = 19'(base + c + stride * r);
      v.corner_b = 19'(base + c + stride * (r + 1));
      v.corner_c = 19'(base + c + 1 + stride * (r + 1));
      v.corner_d = 19'(base + c + 1 + stride * r);
    end else begin
      v.corner_a = '0;
      v.corner_b = '0;
      v.corner_c = '0;
      v.corner_d = '0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // The receiver stalls at random unless the no-idle stretch is on.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b1;
    end else begin
      rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 16);
    end
  end

  // Every accepted response is compared against the oldest pending vertex.
  always @(posedge clk) begin
    vertex_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_vertices.size() == 0) begin
        report_mismatch("unexpected response", 1, 0);
      end else begin
        want = pending_vertices.pop_front();
        if (rsp_ch.pos_x !== want.pos_x) report_mismatch("pos_x", rsp_ch.pos_x, want.pos_x);
        if (rsp_ch.pos_y !== want.pos_y) report_mismatch("pos_y", rsp_ch.pos_y, want.pos_y);
        if (rsp_ch.pos_z !== want.pos_z) report_mismatch("pos_z", rsp_ch.pos_z, want.pos_z);
        if (rsp_ch.normal_code !== want.normal_code)
          report_mismatch("normal_code", rsp_ch.normal_code, want.normal_code);
        if (rsp_ch.tex_u !== want.tex_u) report_mismatch("tex_u", rsp_ch.tex_u, want.tex_u);
        if (rsp_ch.tex_v !== want.tex_v) report_mismatch("tex_v", rsp_ch.tex_v, want.tex_v);
        if (rsp_ch.corner_a !== want.corner_a)
          report_mismatch("corner_a", rsp_ch.corner_a, want.corner_a);
        if (rsp_ch.corner_b !== want.corner_b)
          report_mismatch("corner_b", rsp_ch.corner_b, want.corner_b);
        if (rsp_ch.corner_c !== want.corner_c)
          report_mismatch("corner_c", rsp_ch.corner_c, want.corner_c);
        if (rsp_ch.corner_d !== want.corner_d)
          report_mismatch("corner_d", rsp_ch.corner_d, want.corner_d);
        if (rsp_ch.quad_valid !== want.quad_valid)
          report_mismatch("quad_valid", rsp_ch.quad_valid, want.quad_valid);
      end
    end
  end

  // Sends one request transaction. Valid stays high from one request to the
  // next unless an idle gap is inserted, so back-to-back traffic is possible.
  task automatic send_vertex_request(logic [2:0] face, logic [7:0] col, logic [7:0] row);
    int gap;
    if (!no_idle && $urandom_range(99) < 7) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.face     <= face;
    req_ch.grid_col <= col;
    req_ch.grid_row <= row;
    do @(posedge clk); while (!req_ch.ready);
    pending_vertices.push_back(predict_vertex(face, col, row));
  endtask

  // Waits until every response has come back, then lets the pipeline settle
  // so that registers can be written safely.
  task automatic drain_pipeline();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Writes one register while the block is idle and mirrors the write.
  task automatic write_register(bmvg_pkg::cfg_reg_t idx, logic [15:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      bmvg_pkg::RegBoxWidth:  ext_x = value;
      bmvg_pkg::RegBoxHeight: ext_y = value;
      bmvg_pkg::RegBoxDepth:  ext_z = value;
      bmvg_pkg::RegSegsX:     seg_x = value[7:0];
      bmvg_pkg::RegSegsY:     seg_y = value[7:0];
      bmvg_pkg::RegSegsZ:     seg_z = value[7:0];
      default: ;
    endcase
  endtask

  task automatic write_box(logic [15:0] w, logic [15:0] h, logic [15:0] d,
                           logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    drain_pipeline();
    write_register(bmvg_pkg::RegBoxWidth, w);
    write_register(bmvg_pkg::RegBoxHeight, h);
    write_register(bmvg_pkg::RegBoxDepth, d);
    write_register(bmvg_pkg::RegSegsX, nx);
    write_register(bmvg_pkg::RegSegsY, ny);
    write_register(bmvg_pkg::RegSegsZ, nz);
  endtask

  // The reset cube: two opposite corners of every face, plus an out-of-grid request.
  task automatic test_reset_cube();
    for (int f = 0; f < 6; f++) begin
      send_vertex_request(3'(f), 8'd0, 8'd0);
      send_vertex_request(3'(f), 8'd1, 8'd1);
    end
    send_vertex_request(bmvg_pkg::FacePosX, 8'd255, 8'd255);
  endtask

  // Largest extents and segment counts, grid edges and the face codes that
  // fold onto the -z face.
  task automatic test_extremes();
    write_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'd255);
    send_vertex_request(bmvg_pkg::FaceNegZ, 8'd254, 8'd254);
    send_vertex_request(bmvg_pkg::FaceNegZ, 8'd255, 8'd0);
    send_vertex_request(bmvg_pkg::FacePosX, 8'd0, 8'd255);
    send_vertex_request(3'd6, 8'd128, 8'd77);
    send_vertex_request(3'd7, 8'd254, 8'd0);
    send_vertex_request(bmvg_pkg::FacePosY, 8'hAA, 8'h55);
  endtask

  // Extents of zero and of one, a zero segment count, and segment data with
  // its upper byte set, which the register must drop.
  task automatic test_degenerate();
    write_box(16'd0, 16'd1, 16'd0, 16'd0, 16'hFF03, 16'h0100);
    for (int f = 0; f < 6; f++) begin
      send_vertex_request(3'(f), 8'd0, 8'd1);
    end
    send_vertex_request(bmvg_pkg::FacePosY, 8'd9, 8'd0);
  endtask

  // Random phases: mostly in-grid requests with a share of saturating ones.
  task automatic test_random_traffic();
    logic [15:0] ext[3];
    logic [15:0] segs[3];
    int lim;
    for (int phase = 0; phase < 8; phase++) begin
      for (int a = 0; a < 3; a++) begin
        ext[a]  = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(1, 2048));
        segs[a] = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(1, 12));
      end
      write_box(ext[0], ext[1], ext[2], segs[0], segs[1], segs[2]);
      no_idle = (phase == 3);
      lim = int'(seg_count(seg_x));
      if (seg_count(seg_y) > lim) lim = int'(seg_count(seg_y));
      if (seg_count(seg_z) > lim) lim = int'(seg_count(seg_z));
      for (int i = 0; i < 72; i++) begin
        if ($urandom_range(4) == 0) begin
          send_vertex_request(3'($urandom_range(7)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
        end else begin
          send_vertex_request(3'($urandom_range(5)), 8'($urandom_range(lim)),
                              8'($urandom_range(lim)));
        end
      end
      no_idle = 0;
    end
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= bmvg_pkg::RegBoxWidth;
    cfg_ch.data  <= '0;
    req_ch.valid <= 1'b0;
    req_ch.face  <= bmvg_pkg::FacePosX;
    req_ch.grid_col <= '0;
    req_ch.grid_row <= '0;
    ext_x = 16'd256;
    ext_y = 16'd256;
    ext_z = 16'd256;
    seg_x = 8'd1;
    seg_y = 8'd1;
    seg_z = 8'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_cube();
    test_extremes();
    test_degenerate();
    test_random_traffic();
    drain_pipeline();

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
